// File: rtl/vgec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgec_pkg
// shared types and constants of the voxel grid exposed cube store
// ----------------------------------------------------------------------------
package vgec_pkg;

    localparam int GRID_SIZE_DEF = 16;

    localparam int POS_W   = 6;
    localparam int TYPE_W  = 3;
    localparam int WORLD_W = 18;
    localparam int CHUNK_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [POS_W-1:0]     WATER_HEIGHT_RST = 6'd8;
    localparam logic [TYPE_W-1:0]    TYPE_EMPTY = 3'd0;
    localparam logic [TYPE_W-1:0]    TYPE_SAND  = 3'd1;
    localparam logic [TYPE_W-1:0]    TYPE_WATER = 3'd4;
    localparam logic [TYPE_W-1:0]    TYPE_LEAVES = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WATER_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_X      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_Z      = 2'd2;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic              status;
        logic              emit;
        logic [TYPE_W-1:0] emit_type;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
    } result_t;

endpackage

// File: rtl/vgec_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgec_ram
// single-port synchronous ram, read-first, registered read data
// ----------------------------------------------------------------------------
module vgec_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/vgec_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgec_seq
// command sequencer: clear pass, read-modify-write of a cell, neighbor scan
// ----------------------------------------------------------------------------
module vgec_seq #(
    parameter int GRID_SIZE = vgec_pkg::GRID_SIZE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          in_kind,
    input  logic [vgec_pkg::POS_W-1:0]          in_x,
    input  logic [vgec_pkg::POS_W-1:0]          in_y,
    input  logic [vgec_pkg::POS_W-1:0]          in_z,
    input  logic [vgec_pkg::TYPE_W-1:0]         in_type,
    input  logic [vgec_pkg::POS_W-1:0]          water_height,
    output logic                                ram_we,
    output logic [$clog2(GRID_SIZE**3)-1:0]     ram_addr,
    output logic [vgec_pkg::TYPE_W-1:0]         ram_wdata,
    input  logic [vgec_pkg::TYPE_W-1:0]         ram_rdata,
    output logic                                res_valid,
    input  logic                                res_ready,
    output vgec_pkg::result_t                   res
);
    import vgec_pkg::*;

    localparam int CW     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int DEPTH  = GRID_SIZE**3;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [2:0] NBR_COUNT = 3'd6;
    localparam logic [POS_W:0] GRID_N = (POS_W+1)'(GRID_SIZE);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_CENTER = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [2:0]          k_reg, k_next;
    logic                pend_reg, pend_next;
    logic [1:0]          kind_reg;
    logic [POS_W-1:0]    x_reg, y_reg, z_reg;
    logic [TYPE_W-1:0]   type_reg;
    logic                inb_reg;
    logic [TYPE_W-1:0]   ctr_reg, ctr_next;
    result_t             res_reg, res_next;

    logic                in_inb;
    logic [POS_W:0]      nx, ny, nz;
    logic [POS_W:0]      dx, dy, dz;
    logic                nb_inb;
    logic [ADDR_W-1:0]   idx_in, idx_ctr, idx_nb;
    logic                add_ok, rem_ok, water_hit, accept;

    function automatic logic [ADDR_W-1:0] cell_idx(input logic [CW-1:0] cx,
                                                   input logic [CW-1:0] cy,
                                                   input logic [CW-1:0] cz);
        return ADDR_W'(cx) * ADDR_W'(GRID_SIZE * GRID_SIZE)
             + ADDR_W'(cz) * ADDR_W'(GRID_SIZE) + ADDR_W'(cy);
    endfunction

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res = res_reg;

    assign in_inb = ({1'b0, in_x} < GRID_N) && ({1'b0, in_y} < GRID_N)
                 && ({1'b0, in_z} < GRID_N);
    assign idx_in  = cell_idx(in_x[CW-1:0], in_y[CW-1:0], in_z[CW-1:0]);
    assign idx_ctr = cell_idx(x_reg[CW-1:0], y_reg[CW-1:0], z_reg[CW-1:0]);

    // face neighbor offsets, minus one wraps to a value above the grid
    always_comb
    begin
        dx = '0;
        dy = '0;
        dz = '0;
        case (k_reg)
            3'd0: dx = 7'd1;
            3'd1: dx = '1;
            3'd2: dz = 7'd1;
            3'd3: dz = '1;
            3'd4: dy = 7'd1;
            3'd5: dy = '1;
            default: ;
        endcase
    end

    assign nx = {1'b0, x_reg} + dx;
    assign ny = {1'b0, y_reg} + dy;
    assign nz = {1'b0, z_reg} + dz;
    assign nb_inb = (nx < GRID_N) && (ny < GRID_N) && (nz < GRID_N);
    assign idx_nb = cell_idx(nx[CW-1:0], ny[CW-1:0], nz[CW-1:0]);

    assign add_ok = inb_reg && (ram_rdata == TYPE_EMPTY)
                 && (type_reg >= TYPE_SAND) && (type_reg <= TYPE_LEAVES);
    assign rem_ok = inb_reg && (ram_rdata != TYPE_EMPTY);
    assign water_hit = (y_reg == water_height);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        k_next     = k_reg;
        pend_next  = pend_reg;
        ctr_next   = ctr_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_addr   = idx_ctr;
        ram_wdata  = TYPE_EMPTY;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                ram_addr = idx_in;
                if (accept)
                begin
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER:
            begin
                res_next.status    = 1'b1;
                res_next.emit      = 1'b0;
                res_next.emit_type = TYPE_EMPTY;
                res_next.pos_x     = x_reg;
                res_next.pos_y     = y_reg;
                res_next.pos_z     = z_reg;
                state_next         = ST_DONE;
                case (kind_reg)
                    KIND_ADD:
                    begin
                        res_next.status = !add_ok;
                        ram_we    = add_ok;
                        ram_wdata = type_reg;
                    end
                    KIND_REMOVE:
                    begin
                        res_next.status = !rem_ok;
                        ram_we = rem_ok;
                    end
                    KIND_QUERY:
                    begin
                        if (inb_reg)
                        begin
                            res_next.status = 1'b0;
                            if (ram_rdata != TYPE_EMPTY)
                            begin
                                ctr_next   = ram_rdata;
                                k_next     = '0;
                                pend_next  = 1'b0;
                                state_next = ST_SCAN;
                            end
                            else if (water_hit)
                            begin
                                res_next.emit      = 1'b1;
                                res_next.emit_type = TYPE_WATER;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ST_SCAN:
            begin
                // one neighbor read issued per cycle, previous one checked
                ram_addr = idx_nb;
                if ((pend_reg && (ram_rdata == TYPE_EMPTY))
                    || ((k_reg != NBR_COUNT) && !nb_inb))
                begin
                    res_next.emit      = 1'b1;
                    res_next.emit_type = ctr_reg;
                    state_next         = ST_DONE;
                end
                else if (k_reg == NBR_COUNT)
                begin
                    res_next.emit      = water_hit;
                    res_next.emit_type = water_hit ? TYPE_WATER : TYPE_EMPTY;
                    state_next         = ST_DONE;
                end
                else
                begin
                    pend_next = 1'b1;
                    k_next    = k_reg + 3'd1;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            k_reg     <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            k_reg     <= k_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= in_kind;
            x_reg    <= in_x;
            y_reg    <= in_y;
            z_reg    <= in_z;
            type_reg <= in_type;
            inb_reg  <= in_inb;
        end
        ctr_reg <= ctr_next;
        res_reg <= res_next;
    end

endmodule

// File: rtl/voxel_grid_exposed_cube_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_grid_exposed_cube_store
// voxel type grid with add, remove and exposed-cube / water query
// ----------------------------------------------------------------------------
// After reset the block sweeps the cell memory to empty, one cell per clock,
// through all GRID_SIZE**3 cells (4096 at the default size); s_tready stays
// low during the sweep while configuration writes are taken as usual. All
// cells sit in one single-port ram with a registered read, so the port sets
// the rate: an add or remove goes through cell read, write back and hand-off
// to the output register, a query of an empty or out-of-bounds cell through
// cell read, check and hand-off. An occupied cell adds a neighbor scan that
// stops at the first neighbor that is outside the grid or empty, or once all
// six neighbors are read, one neighbor read per cycle. The next item is
// taken while a result still waits in the output register.
module voxel_grid_exposed_cube_store #(
    parameter int GRID_SIZE = vgec_pkg::GRID_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pos_x[5:0], pos_y[11:6], pos_z[17:12], new_type[20:18]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // emit_type[2:0], world_x[20:3], world_y[26:21], world_z[44:27]
    output logic [1:0]  m_tuser,   // status[0], emit[1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [vgec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vgec_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vgec_pkg::*;

    localparam int DEPTH  = GRID_SIZE**3;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [WORLD_W-1:0] GRID_W = WORLD_W'(GRID_SIZE);

    logic [POS_W-1:0]   water_height_reg;
    logic [CHUNK_W-1:0] chunk_x_reg, chunk_z_reg;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [TYPE_W-1:0]  ram_wdata, ram_rdata;

    logic               res_valid, res_ready;
    result_t            res;

    logic               m_tvalid_reg;
    logic [47:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    logic [WORLD_W-1:0] cx_ext, cz_ext, wx, wz;
    logic [WORLD_W-1:0] wx_out, wz_out;
    logic [POS_W-1:0]   wy_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            water_height_reg <= WATER_HEIGHT_RST;
            chunk_x_reg      <= '0;
            chunk_z_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WATER_HEIGHT: water_height_reg <= cfg_data[POS_W-1:0];
                CFG_CHUNK_X:      chunk_x_reg      <= cfg_data;
                CFG_CHUNK_Z:      chunk_z_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    vgec_ram #(
        .WIDTH (TYPE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    vgec_seq #(
        .GRID_SIZE (GRID_SIZE)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_kind      (s_tuser),
        .in_x         (s_tdata[5:0]),
        .in_y         (s_tdata[11:6]),
        .in_z         (s_tdata[17:12]),
        .in_type      (s_tdata[20:18]),
        .water_height (water_height_reg),
        .ram_we       (ram_we),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // world position wraps to 18 bits
    assign cx_ext = {{(WORLD_W-CHUNK_W){chunk_x_reg[CHUNK_W-1]}}, chunk_x_reg};
    assign cz_ext = {{(WORLD_W-CHUNK_W){chunk_z_reg[CHUNK_W-1]}}, chunk_z_reg};
    assign wx = cx_ext * GRID_W + WORLD_W'(res.pos_x);
    assign wz = cz_ext * GRID_W + WORLD_W'(res.pos_z);

    assign wx_out = res.emit ? wx : '0;
    assign wz_out = res.emit ? wz : '0;
    assign wy_out = res.emit ? res.pos_y : '0;

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= {3'b000, wz_out, wy_out, wx_out, res.emit_type};
            m_tuser_reg <= {res.emit, res.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the voxel grid exposed cube store: a directed
// table, then random add, remove and query traffic clustered in small regions
// so that hidden cells and water layers occur, under several idling mixes
// and register settings. Results are predicted from a local copy of the grid.
// ----------------------------------------------------------------------------
module testbench;
    import vgec_pkg::*;

    localparam int GRID           = GRID_SIZE_DEF;
    localparam int CELLS          = GRID * GRID * GRID;
    localparam int REGION         = 4;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 24;
    localparam int PRINT_LIMIT    = 40;
    localparam int TIMEOUT_NS     = 3_000_000;

    localparam logic ST_ACCEPTED = 1'b0;
    localparam logic ST_REJECTED = 1'b1;

    localparam logic [TYPE_W-1:0] TYPE_DIRT  = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_GRASS = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_LOG   = 3'd5;
    localparam logic [TYPE_W-1:0] TYPE_BAD   = 3'd7;

    typedef enum int {
        MODE_NO_IDLE,
        MODE_SENDER_IDLE,
        MODE_RECEIVER_STALL,
        MODE_BOTH_IDLE
    } idle_mode_t;

    typedef struct packed {
        kind_t              kind;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [POS_W-1:0]   z;
        logic [TYPE_W-1:0]  ntype;
    } voxel_cmd_t;

    typedef struct packed {
        logic                       status;
        logic                       emit;
        logic [TYPE_W-1:0]          emit_type;
        logic signed [WORLD_W-1:0]  world_x;
        logic [POS_W-1:0]           world_y;
        logic signed [WORLD_W-1:0]  world_z;
    } cube_result_t;

    typedef struct packed {
        voxel_cmd_t    cmd;
        logic          typed;
        cube_result_t  want;
    } directed_row_t;

    localparam cube_result_t QUIET_OK = '{ST_ACCEPTED, 1'b0, TYPE_EMPTY, 18'sd0, 6'd0, 18'sd0};
    localparam cube_result_t REJECTED = '{ST_REJECTED, 1'b0, TYPE_EMPTY, 18'sd0, 6'd0, 18'sd0};

    localparam int DIRECTED_COUNT = 25;

    // rows with typed = 0 take their expectation from the predictor
    directed_row_t directed_rows [DIRECTED_COUNT] = '{
        '{'{KIND_QUERY,  6'd0,  6'd0,  6'd0,  TYPE_EMPTY},  1'b1, QUIET_OK},
        '{'{KIND_QUERY,  6'd3,  6'd8,  6'd3,  TYPE_EMPTY},  1'b1,
          '{ST_ACCEPTED, 1'b1, TYPE_WATER, 18'sd3, 6'd8, 18'sd3}},
        '{'{KIND_ADD,    6'd0,  6'd0,  6'd0,  TYPE_SAND},   1'b1, QUIET_OK},
        '{'{KIND_ADD,    6'd0,  6'd0,  6'd0,  TYPE_DIRT},   1'b1, REJECTED},
        '{'{KIND_ADD,    6'd15, 6'd15, 6'd15, TYPE_LEAVES}, 1'b1, QUIET_OK},
        '{'{KIND_ADD,    6'd16, 6'd0,  6'd0,  TYPE_SAND},   1'b1, REJECTED},
        '{'{KIND_ADD,    6'd1,  6'd1,  6'd1,  TYPE_EMPTY},  1'b1, REJECTED},
        '{'{KIND_ADD,    6'd1,  6'd1,  6'd1,  TYPE_BAD},    1'b1, REJECTED},
        '{'{KIND_REMOVE, 6'd2,  6'd2,  6'd2,  TYPE_SAND},   1'b1, REJECTED},
        '{'{KIND_REMOVE, 6'd63, 6'd63, 6'd63, TYPE_BAD},    1'b1, REJECTED},
        '{'{KIND_NONE,   6'd1,  6'd1,  6'd1,  TYPE_GRASS},  1'b1, REJECTED},
        '{'{KIND_QUERY,  6'd0,  6'd63, 6'd0,  TYPE_EMPTY},  1'b1, REJECTED},
        '{'{KIND_QUERY,  6'd0,  6'd0,  6'd0,  TYPE_EMPTY},  1'b1,
          '{ST_ACCEPTED, 1'b1, TYPE_SAND, 18'sd0, 6'd0, 18'sd0}},
        '{'{KIND_QUERY,  6'd15, 6'd15, 6'd15, TYPE_EMPTY},  1'b1,
          '{ST_ACCEPTED, 1'b1, TYPE_LEAVES, 18'sd15, 6'd15, 18'sd15}},
        // bury (5,8,5) on all six faces at the reset water height
        '{'{KIND_ADD,    6'd5,  6'd8,  6'd5,  TYPE_GRASS},  1'b1, QUIET_OK},
        '{'{KIND_ADD,    6'd6,  6'd8,  6'd5,  TYPE_DIRT},   1'b1, QUIET_OK},
        '{'{KIND_ADD,    6'd4,  6'd8,  6'd5,  TYPE_DIRT},   1'b1, QUIET_OK},
        '{'{KIND_ADD,    6'd5,  6'd9,  6'd5,  TYPE_LOG},    1'b1, QUIET_OK},
        '{'{KIND_ADD,    6'd5,  6'd7,  6'd5,  TYPE_LOG},    1'b1, QUIET_OK},
        '{'{KIND_ADD,    6'd5,  6'd8,  6'd6,  TYPE_WATER},  1'b1, QUIET_OK},
        '{'{KIND_ADD,    6'd5,  6'd8,  6'd4,  TYPE_SAND},   1'b1, QUIET_OK},
        // hidden but at water height, so water replaces it
        '{'{KIND_QUERY,  6'd5,  6'd8,  6'd5,  TYPE_EMPTY},  1'b1,
          '{ST_ACCEPTED, 1'b1, TYPE_WATER, 18'sd5, 6'd8, 18'sd5}},
        '{'{KIND_QUERY,  6'd6,  6'd8,  6'd5,  TYPE_EMPTY},  1'b0, QUIET_OK},
        '{'{KIND_QUERY,  6'd5,  6'd8,  6'd4,  TYPE_EMPTY},  1'b0, QUIET_OK},
        '{'{KIND_REMOVE, 6'd0,  6'd0,  6'd0,  TYPE_EMPTY},  1'b1, QUIET_OK}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;   // pos_x[5:0], pos_y[11:6], pos_z[17:12], new_type[20:18]
    logic [1:0]            s_tuser;   // kind[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;   // emit_type[2:0], world_x[20:3], world_y[26:21], world_z[44:27]
    logic [1:0]            m_tuser;   // status[0], emit[1]
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // local copy of the grid and registers
    logic [TYPE_W-1:0]  cell_types [CELLS];
    logic [POS_W-1:0]   water_level;
    logic [CHUNK_W-1:0] chunk_x_sel;
    logic [CHUNK_W-1:0] chunk_z_sel;

    cube_result_t pending_results [$];
    idle_mode_t   idle_mode = MODE_NO_IDLE;
    int           holdoff_left = 0;
    int           error_count = 0;
    int           result_count = 0;
    int           region_x, region_y, region_z;

    voxel_grid_exposed_cube_store u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit in_grid(int x, int y, int z);
        return x >= 0 && x < GRID && y >= 0 && y < GRID && z >= 0 && z < GRID;
    endfunction

    function automatic int cell_of(int x, int y, int z);
        return (x * GRID + z) * GRID + y;
    endfunction

    function automatic bit open_face(int x, int y, int z);
        if (!in_grid(x, y, z))
            return 1'b1;
        return cell_types[cell_of(x, y, z)] == TYPE_EMPTY;
    endfunction

    // updates the local grid and returns what the block must answer
    function automatic cube_result_t predict_cube_result(voxel_cmd_t c);
        cube_result_t r;
        int x, y, z, slot;
        bit inb, exposed;
        logic [TYPE_W-1:0] occupant;
        x = int'(c.x);
        y = int'(c.y);
        z = int'(c.z);
        r = REJECTED;
        inb = in_grid(x, y, z);
        slot = inb ? cell_of(x, y, z) : 0;
        case (c.kind)
            KIND_ADD:
            begin
                if (inb && cell_types[slot] == TYPE_EMPTY &&
                    c.ntype >= TYPE_SAND && c.ntype <= TYPE_LEAVES)
                begin
                    cell_types[slot] = c.ntype;
                    r.status = ST_ACCEPTED;
                end
            end
            KIND_REMOVE:
            begin
                if (inb && cell_types[slot] != TYPE_EMPTY)
                begin
                    cell_types[slot] = TYPE_EMPTY;
                    r.status = ST_ACCEPTED;
                end
            end
            KIND_QUERY:
            begin
                if (inb)
                begin
                    occupant = cell_types[slot];
                    exposed = open_face(x + 1, y, z) || open_face(x - 1, y, z) ||
                              open_face(x, y + 1, z) || open_face(x, y - 1, z) ||
                              open_face(x, y, z + 1) || open_face(x, y, z - 1);
                    r.status = ST_ACCEPTED;
                    if (occupant != TYPE_EMPTY && exposed)
                    begin
                        r.emit = 1'b1;
                        r.emit_type = occupant;
                    end
                    else if (c.y == water_level)
                    begin
                        r.emit = 1'b1;
                        r.emit_type = TYPE_WATER;
                    end
                end
            end
            default: ;
        endcase
        if (r.emit)
        begin
            r.world_x = WORLD_W'(int'(signed'(chunk_x_sel)) * GRID + x);
            r.world_y = c.y;
            r.world_z = WORLD_W'(int'(signed'(chunk_z_sel)) * GRID + z);
        end
        return r;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            MODE_SENDER_IDLE: return $urandom_range(99) < 77;
            MODE_BOTH_IDLE:   return $urandom_range(99) < 31;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            MODE_RECEIVER_STALL: return $urandom_range(99) < 77;
            MODE_BOTH_IDLE:      return $urandom_range(99) < 31;
            default:             return 1'b0;
        endcase
    endfunction

    function automatic voxel_cmd_t random_cmd();
        voxel_cmd_t c;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40)
            c.kind = KIND_ADD;
        else if (roll < 55)
            c.kind = KIND_REMOVE;
        else if (roll < 96)
            c.kind = KIND_QUERY;
        else
            c.kind = KIND_NONE;
        roll = $urandom_range(99);
        if (roll < 70)
        begin
            c.x = POS_W'(region_x + $urandom_range(REGION - 1));
            c.y = POS_W'(region_y + $urandom_range(REGION - 1));
            c.z = POS_W'(region_z + $urandom_range(REGION - 1));
        end
        else if (roll < 88)
        begin
            c.x = POS_W'($urandom_range(GRID - 1));
            c.y = POS_W'($urandom_range(GRID - 1));
            c.z = POS_W'($urandom_range(GRID - 1));
        end
        else
        begin
            c.x = POS_W'($urandom_range(63));
            c.y = POS_W'($urandom_range(63));
            c.z = POS_W'($urandom_range(63));
        end
        if ($urandom_range(99) < 92)
            c.ntype = TYPE_W'($urandom_range(TYPE_LEAVES, TYPE_SAND));
        else
            c.ntype = $urandom_range(1) ? TYPE_BAD : TYPE_EMPTY;
        return c;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] error: %s", $time, msg);
    endtask

    task automatic check_result(input cube_result_t got);
        cube_result_t want;
        result_count++;
        if (pending_results.size() == 0)
        begin
            report_error($sformatf("result %0d arrived with nothing outstanding", result_count));
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
            report_error($sformatf("result %0d status %0d, expected %0d",
                                   result_count, got.status, want.status));
        if (got.emit !== want.emit)
            report_error($sformatf("result %0d emit %0d, expected %0d",
                                   result_count, got.emit, want.emit));
        if (got.emit_type !== want.emit_type)
            report_error($sformatf("result %0d emit_type %0d, expected %0d",
                                   result_count, got.emit_type, want.emit_type));
        if (got.world_x !== want.world_x)
            report_error($sformatf("result %0d world_x %0d, expected %0d",
                                   result_count, got.world_x, want.world_x));
        if (got.world_y !== want.world_y)
            report_error($sformatf("result %0d world_y %0d, expected %0d",
                                   result_count, got.world_y, want.world_y));
        if (got.world_z !== want.world_z)
            report_error($sformatf("result %0d world_z %0d, expected %0d",
                                   result_count, got.world_z, want.world_z));
    endtask

    // offers one item and books its expected result at the transfer
    task automatic send_cmd(input voxel_cmd_t c, input logic typed, input cube_result_t want);
        cube_result_t predicted;
        while (sender_idles())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, c.ntype, c.z, c.y, c.x};
        s_tuser  <= c.kind;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_cube_result(c);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic [POS_W-1:0] water, input logic [CHUNK_W-1:0] cx,
                             input logic [CHUNK_W-1:0] cz);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WATER_HEIGHT;
        cfg_data  <= CFG_DATA_W'(water);
        do
            @(posedge clk);
        while (!cfg_ready);
        water_level = water;
        cfg_index <= CFG_CHUNK_X;
        cfg_data  <= cx;
        do
            @(posedge clk);
        while (!cfg_ready);
        chunk_x_sel = cx;
        cfg_index <= CFG_CHUNK_Z;
        cfg_data  <= cz;
        do
            @(posedge clk);
        while (!cfg_ready);
        chunk_z_sel = cz;
        cfg_valid <= 1'b0;
    endtask

    // a negative water value puts the water layer inside the busy region
    task automatic run_phase(input idle_mode_t mode, input int count, input int water,
                             input logic [CHUNK_W-1:0] cx, input logic [CHUNK_W-1:0] cz,
                             input int holdoff_at);
        region_x = $urandom_range(GRID - REGION);
        region_y = $urandom_range(GRID - REGION);
        region_z = $urandom_range(GRID - REGION);
        if (water < 0)
            water = region_y + $urandom_range(1, 2);
        configure(POS_W'(water), cx, cz);
        idle_mode = mode;
        for (int i = 0; i < count; i++)
        begin
            if (i == holdoff_at)
                holdoff_left = HOLDOFF_CYCLES;
            send_cmd(random_cmd(), 1'b0, QUIET_OK);
        end
        drain_results();
    endtask

    initial
    begin : receiver
        cube_result_t got;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.status    = m_tuser[0];
                got.emit      = m_tuser[1];
                got.emit_type = m_tdata[2:0];
                got.world_x   = m_tdata[20:3];
                got.world_y   = m_tdata[26:21];
                got.world_z   = m_tdata[44:27];
                check_result(got);
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !receiver_stalls();
        end
    end

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_NONE;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_WATER_HEIGHT;
        cfg_data  <= '0;
        foreach (cell_types[i])
            cell_types[i] = TYPE_EMPTY;
        water_level = WATER_HEIGHT_RST;
        chunk_x_sel = '0;
        chunk_z_sel = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values are in force for the table
        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        run_phase(MODE_NO_IDLE,        300, 0,  13'h0fff, 13'h1000, 100);
        run_phase(MODE_SENDER_IDLE,    300, 63, 13'h1000, 13'h0fff, -1);
        run_phase(MODE_RECEIVER_STALL, 300, 15, 13'h1fff, 13'h0001, -1);
        // water layer above the grid never fires
        run_phase(MODE_BOTH_IDLE,      300, GRID, 13'h0000, 13'h0000, -1);
        run_phase(MODE_NO_IDLE,        250, -1, CHUNK_W'($urandom_range(8191)),
                  CHUNK_W'($urandom_range(8191)), 120);
        run_phase(MODE_BOTH_IDLE,      200, -1, CHUNK_W'($urandom_range(8191)),
                  CHUNK_W'($urandom_range(8191)), -1);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("voxel_grid_exposed_cube_store test passed");
        else
            $display("voxel_grid_exposed_cube_store test failed");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("voxel_grid_exposed_cube_store test failed");
        $finish;
    end

endmodule

// File: files.f
rtl/vgec_pkg.sv
rtl/vgec_ram.sv
rtl/vgec_seq.sv
rtl/voxel_grid_exposed_cube_store.sv
sim/testbench.sv
